// ===== src/rvcs_pkg.sv =====
package rvcs_pkg;

    localparam int XLEN      = 32;
    localparam int REG_COUNT = 32;
    localparam int REG_IDX_W = 5;

    // Major opcodes
    localparam logic [6:0] OP_HALT  = 7'h00;
    localparam logic [6:0] OP_LUI   = 7'h37;
    localparam logic [6:0] OP_AUIPC = 7'h17;
    localparam logic [6:0] OP_IMM   = 7'h13;
    localparam logic [6:0] OP_REG   = 7'h33;
    localparam logic [6:0] OP_STORE = 7'h23;
    localparam logic [6:0] OP_BRAN  = 7'h63;

    // funct3 codes for ALU operations
    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_SLTU = 3'd3;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_SRL  = 3'd5;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;

    // funct3 codes for stores and branches
    localparam logic [2:0] F3_SW  = 3'd2;
    localparam logic [2:0] F3_BEQ = 3'd0;
    localparam logic [2:0] F3_BNE = 3'd1;
    localparam logic [2:0] F3_BLT = 3'd4;
    localparam logic [2:0] F3_BGE = 3'd5;

    // funct7 codes
    localparam logic [6:0] F7_BASE = 7'h00;
    localparam logic [6:0] F7_ALT  = 7'h20;

    localparam logic [XLEN-1:0] PC_STEP = 32'd4;

    typedef struct packed {
        logic [XLEN-1:0]      next_pc;
        logic                 store_valid;
        logic [XLEN-1:0]      store_addr;
        logic [XLEN-1:0]      store_data;
        logic                 reg_write_valid;
        logic [REG_IDX_W-1:0] reg_write_index;
        logic [XLEN-1:0]      reg_write_value;
        logic                 halted;
        logic                 unsupported;
    } t_result;

endpackage

// ===== src/rv32i_subset_core_step_top.sv =====
// Channel   Direction  Handshake                      Payload
// in        input      i_in_valid / o_in_stall        i_instr_word
// out       output     o_out_valid / i_out_stall      o_next_pc .. o_unsupported
// config    input      i_cfg_wr_en                    i_cfg_wr_data (start address)
//
// One instruction retires per clock while the output is not stalled. The register-file
// RAM reads both source registers at the accepting edge; the operand stage then decodes,
// executes and loads the result register. Results forward from the execute step into the
// operand stage, so dependent instructions run back to back.
// Reset is synchronous: PC to zero, halt cleared, and per-entry valid bits make every
// register read as zero, so no clearing pass is needed.
// A stalled output holds its result; one more instruction waits in the operand stage
// before o_in_stall rises.
module rv32i_subset_core_step_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_instr_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_next_pc,
    output logic        o_store_valid,
    output logic [31:0] o_store_addr,
    output logic [31:0] o_store_data,
    output logic        o_reg_write_valid,
    output logic [4:0]  o_reg_write_index,
    output logic [31:0] o_reg_write_value,
    output logic        o_halted,
    output logic        o_unsupported
);

    logic                        r_s1_valid;
    logic [31:0]                 r_s1_instr;
    logic                        r_fwd_a;
    logic                        r_fwd_b;
    logic [31:0]                 r_fwd_val;
    logic                        r_vld_a;
    logic                        r_vld_b;
    logic [rvcs_pkg::REG_COUNT-1:0] r_reg_vld;
    logic [31:0]                 r_pc;
    logic                        r_halt;
    logic                        r_out_valid;
    rvcs_pkg::t_result           r_out;

    logic              w_out_free;
    logic              w_s1_adv;
    logic              w_accept;
    logic              w_ex_wr;
    logic [4:0]        w_rs1;
    logic [4:0]        w_rs2;
    logic [31:0]       w_ram_a;
    logic [31:0]       w_ram_b;
    logic [31:0]       w_op_a;
    logic [31:0]       w_op_b;
    rvcs_pkg::t_result w_res;

    // handshake
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_s1_adv   = r_s1_valid && w_out_free;
    assign o_in_stall = r_s1_valid && !w_out_free;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_rs1   = i_instr_word[19:15];
    assign w_rs2   = i_instr_word[24:20];
    assign w_ex_wr = w_s1_adv && w_res.reg_write_valid;

    // register file storage
    rvcs_ram #(
        .WIDTH (rvcs_pkg::XLEN),
        .DEPTH (rvcs_pkg::REG_COUNT)
    ) u_regfile (
        .i_clk       (i_clk),
        .i_wr_en     (w_ex_wr),
        .i_wr_addr   (w_res.reg_write_index),
        .i_wr_data   (w_res.reg_write_value),
        .i_rd_en     (w_accept),
        .i_rd_addr_a (w_rs1),
        .i_rd_addr_b (w_rs2),
        .o_rd_data_a (w_ram_a),
        .o_rd_data_b (w_ram_b)
    );

    // operand stage: capture beat, entry valid bits and forwarding from execute
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_accept) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_instr <= i_instr_word;
            r_vld_a    <= r_reg_vld[w_rs1];
            r_vld_b    <= r_reg_vld[w_rs2];
            r_fwd_a    <= w_ex_wr && (w_res.reg_write_index == w_rs1);
            r_fwd_b    <= w_ex_wr && (w_res.reg_write_index == w_rs2);
            r_fwd_val  <= w_res.reg_write_value;
        end
    end

    assign w_op_a = r_fwd_a ? r_fwd_val : (r_vld_a ? w_ram_a : '0);
    assign w_op_b = r_fwd_b ? r_fwd_val : (r_vld_b ? w_ram_b : '0);

    rvcs_exec u_exec (
        .i_instr (r_s1_instr),
        .i_pc    (r_pc),
        .i_op_a  (w_op_a),
        .i_op_b  (w_op_b),
        .i_halt  (r_halt),
        .o_res   (w_res)
    );

    // architectural state: PC, halt flag, register valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc      <= '0;
            r_halt    <= 1'b0;
            r_reg_vld <= '0;
        end else if (i_cfg_wr_en) begin
            r_pc <= i_cfg_wr_data;
        end else if (w_s1_adv) begin
            r_pc   <= w_res.next_pc;
            r_halt <= w_res.halted;
            if (w_res.reg_write_valid) begin
                r_reg_vld[w_res.reg_write_index] <= 1'b1;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_next_pc         = r_out.next_pc;
    assign o_store_valid     = r_out.store_valid;
    assign o_store_addr      = r_out.store_addr;
    assign o_store_data      = r_out.store_data;
    assign o_reg_write_valid = r_out.reg_write_valid;
    assign o_reg_write_index = r_out.reg_write_index;
    assign o_reg_write_value = r_out.reg_write_value;
    assign o_halted          = r_out.halted;
    assign o_unsupported     = r_out.unsupported;

    // checks
    a_no_x0_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.reg_write_valid) |-> (r_out.reg_write_index != '0))
        else $error("register write to x0 delivered");

    a_one_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.store_valid && r_out.reg_write_valid))
        else $error("store and register write in one result");

    a_halt_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared without reset");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_adv) |=> (r_s1_valid && r_s1_instr == $past(r_s1_instr)))
        else $error("operand stage lost a held instruction");

    a_bad_no_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.unsupported) |->
            (!r_out.reg_write_valid && !r_out.store_valid))
        else $error("unsupported instruction caused a write");

endmodule

// ===== src/rvcs_ram.sv =====
module rvcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]         o_rd_data_a,
    output logic [WIDTH-1:0]         o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data_a;
    logic [WIDTH-1:0] r_rd_data_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // two registered read ports
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data_a <= r_mem[i_rd_addr_a];
            r_rd_data_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_data_a;
    assign o_rd_data_b = r_rd_data_b;

endmodule

// ===== src/rvcs_exec.sv =====
module rvcs_exec (
    input  logic [31:0]              i_instr,
    input  logic [31:0]              i_pc,
    input  logic [31:0]              i_op_a,
    input  logic [31:0]              i_op_b,
    input  logic                     i_halt,
    output rvcs_pkg::t_result        o_res
);

    always_comb begin
        logic [6:0]  op;
        logic [4:0]  rd;
        logic [2:0]  f3;
        logic [6:0]  f7;
        logic [31:0] imm_i;
        logic [31:0] imm_s;
        logic [31:0] imm_b;
        logic [31:0] imm_u;
        logic [4:0]  sh;
        logic [31:0] pc_inc;
        logic        lt;
        logic        take;
        logic        wr;
        logic        bad;
        logic [31:0] val;

        op     = i_instr[6:0];
        rd     = i_instr[11:7];
        f3     = i_instr[14:12];
        f7     = i_instr[31:25];
        imm_i  = {{20{i_instr[31]}}, i_instr[31:20]};
        imm_s  = {{20{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
        imm_b  = {{19{i_instr[31]}}, i_instr[31], i_instr[7], i_instr[30:25],
                  i_instr[11:8], 1'b0};
        imm_u  = {i_instr[31:12], 12'd0};
        sh     = i_op_b[4:0];
        pc_inc = i_pc + rvcs_pkg::PC_STEP;
        lt     = $signed(i_op_a) < $signed(i_op_b);
        take   = 1'b0;
        wr     = 1'b0;
        bad    = 1'b0;
        val    = '0;
        o_res  = '0;

        // decode and execute
        case (op)
            rvcs_pkg::OP_LUI: begin
                wr  = 1'b1;
                val = imm_u;
            end
            rvcs_pkg::OP_AUIPC: begin
                wr  = 1'b1;
                val = i_pc + imm_u;
            end
            rvcs_pkg::OP_IMM: begin
                if (f3 == rvcs_pkg::F3_ADD) begin
                    wr  = 1'b1;
                    val = i_op_a + imm_i;
                end else if (f3 == rvcs_pkg::F3_SLL && f7 == rvcs_pkg::F7_BASE) begin
                    wr  = 1'b1;
                    val = i_op_a << i_instr[24:20];
                end else begin
                    bad = 1'b1;
                end
            end
            rvcs_pkg::OP_REG: begin
                if ((f7 != rvcs_pkg::F7_BASE &&
                     !(f7 == rvcs_pkg::F7_ALT &&
                       (f3 == rvcs_pkg::F3_ADD || f3 == rvcs_pkg::F3_SRL))) ||
                    f3 == rvcs_pkg::F3_SLTU) begin
                    bad = 1'b1;
                end else begin
                    wr = 1'b1;
                    case (f3)
                        rvcs_pkg::F3_ADD: val = (f7 == rvcs_pkg::F7_ALT) ?
                                                i_op_a - i_op_b : i_op_a + i_op_b;
                        rvcs_pkg::F3_SLL: val = i_op_a << sh;
                        rvcs_pkg::F3_SLT: val = {31'd0, lt};
                        rvcs_pkg::F3_XOR: val = i_op_a ^ i_op_b;
                        rvcs_pkg::F3_SRL: val = (f7 == rvcs_pkg::F7_ALT) ?
                                                32'($signed(i_op_a) >>> sh) :
                                                i_op_a >> sh;
                        rvcs_pkg::F3_OR:  val = i_op_a | i_op_b;
                        rvcs_pkg::F3_AND: val = i_op_a & i_op_b;
                        default:          val = '0;
                    endcase
                end
            end
            rvcs_pkg::OP_STORE: begin
                if (f3 == rvcs_pkg::F3_SW) begin
                    o_res.store_valid = 1'b1;
                    o_res.store_addr  = i_op_a + imm_s;
                    o_res.store_data  = i_op_b;
                end else begin
                    bad = 1'b1;
                end
            end
            rvcs_pkg::OP_BRAN: begin
                case (f3)
                    rvcs_pkg::F3_BEQ: take = (i_op_a == i_op_b);
                    rvcs_pkg::F3_BNE: take = (i_op_a != i_op_b);
                    rvcs_pkg::F3_BLT: take = lt;
                    rvcs_pkg::F3_BGE: take = !lt;
                    default:          bad  = 1'b1;
                endcase
            end
            rvcs_pkg::OP_HALT: begin
                o_res.halted = 1'b1;
            end
            default: begin
                bad = 1'b1;
            end
        endcase

        o_res.next_pc     = take ? i_pc + imm_b : pc_inc;
        o_res.unsupported = bad;

        // drop writes to x0
        if (wr && rd != '0) begin
            o_res.reg_write_valid = 1'b1;
            o_res.reg_write_index = rd;
            o_res.reg_write_value = val;
        end

        // a halted core ignores the word and holds the PC
        if (i_halt) begin
            o_res         = '0;
            o_res.next_pc = i_pc;
            o_res.halted  = 1'b1;
        end
    end

endmodule
